>>> sv/qrr_pkg.sv
`timescale 1ns / 1ps

package qrr_pkg;

    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_W    = 40;

    // discriminant: signed working width and magnitude width when not negative
    localparam int DS_W  = 2 * COEF_W + 3;
    localparam int DW    = 2 * COEF_W + 1;
    // radicand D * 2^(2F), rounded up to an even bit count
    localparam int RAD_W = ((DW + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int SQ_W  = RAD_W / 2;
    localparam int REM_W = SQ_W + 2;
    // numerator magnitude and signed width, divisor magnitude width
    localparam int NM_W  = ((SQ_W > COEF_W + FRAC_BITS) ? SQ_W : COEF_W + FRAC_BITS) + 1;
    localparam int NS_W  = NM_W + 1;
    localparam int DEN_W = COEF_W + 1;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic [1:0]               cnt;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [SQ_W-1:0]  root;
        t_side            side;
    } t_sq;

    typedef struct packed {
        logic [NM_W-1:0]  nm_p;
        logic [NM_W-1:0]  nm_m;
        logic [DEN_W-1:0] rm_p;
        logic [DEN_W-1:0] rm_m;
        logic             neg_p;
        logic             neg_m;
        logic [DEN_W-1:0] den;
        logic [1:0]       cnt;
    } t_dv;

    typedef struct packed {
        logic [1:0]               cnt;
        logic signed [ROOT_W-1:0] rp;
        logic signed [ROOT_W-1:0] rm;
    } t_res;

endpackage

>>> sv/qrr_if.sv
`timescale 1ns / 1ps

interface qrr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qrr_pkg::COEF_W-1:0]   coef_a;
    logic signed [qrr_pkg::COEF_W-1:0]   coef_b;
    logic signed [qrr_pkg::COEF_W-1:0]   coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          root_count;
    logic signed [qrr_pkg::ROOT_W-1:0]   root_plus;
    logic signed [qrr_pkg::ROOT_W-1:0]   root_minus;

    modport source (output valid, root_count, root_plus, root_minus, input ready);
    modport sink   (input valid, root_count, root_plus, root_minus, output ready);
endinterface

>>> sv/qrr_sqrt_cell.sv
`timescale 1ns / 1ps

// one root bit per cell: restoring digit step on the next radicand pair
module qrr_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  qrr_pkg::t_sq   i_d,
    output logic           o_v,
    output qrr_pkg::t_sq   o_d
);

    logic                       r_v;
    qrr_pkg::t_sq               r_d;
    qrr_pkg::t_sq               n_d;
    logic [qrr_pkg::REM_W+1:0]  w_cur;
    logic [qrr_pkg::REM_W+1:0]  w_trial;

    always_comb begin
        w_cur   = {i_d.rem, i_d.rad[qrr_pkg::RAD_W-1 -: 2]};
        w_trial = (qrr_pkg::REM_W + 2)'({i_d.root, 2'b01});
        n_d      = i_d;
        n_d.rad  = {i_d.rad[qrr_pkg::RAD_W-3:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_d.rem  = qrr_pkg::REM_W'(w_cur - w_trial);
            n_d.root = {i_d.root[qrr_pkg::SQ_W-2:0], 1'b1};
        end else begin
            n_d.rem  = qrr_pkg::REM_W'(w_cur);
            n_d.root = {i_d.root[qrr_pkg::SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule

>>> sv/qrr_div_cell.sv
`timescale 1ns / 1ps

// one quotient bit per cell for both roots: restoring division step
module qrr_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  qrr_pkg::t_dv   i_d,
    output logic           o_v,
    output qrr_pkg::t_dv   o_d
);

    logic                       r_v;
    qrr_pkg::t_dv               r_d;
    qrr_pkg::t_dv               n_d;
    logic [qrr_pkg::DEN_W:0]    w_sp;
    logic [qrr_pkg::DEN_W:0]    w_sm;
    logic [qrr_pkg::DEN_W:0]    w_den;
    logic                       w_qp;
    logic                       w_qm;

    always_comb begin
        w_den = {1'b0, i_d.den};
        w_sp  = {i_d.rm_p, i_d.nm_p[qrr_pkg::NM_W-1]};
        w_sm  = {i_d.rm_m, i_d.nm_m[qrr_pkg::NM_W-1]};
        w_qp  = (w_sp >= w_den);
        w_qm  = (w_sm >= w_den);
        n_d      = i_d;
        n_d.rm_p = w_qp ? qrr_pkg::DEN_W'(w_sp - w_den) : qrr_pkg::DEN_W'(w_sp);
        n_d.rm_m = w_qm ? qrr_pkg::DEN_W'(w_sm - w_den) : qrr_pkg::DEN_W'(w_sm);
        n_d.nm_p = {i_d.nm_p[qrr_pkg::NM_W-2:0], w_qp};
        n_d.nm_m = {i_d.nm_m[qrr_pkg::NM_W-2:0], w_qm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;

endmodule

>>> sv/quadratic_real_roots.sv
`timescale 1ns / 1ps
// Pipeline: 3 + SQ_W + 1 + NM_W + 1 stages, then the output register.
// Throughput: one coefficient set per cycle while the chain is not frozen; all chain stages share one enable.
// A full output with a stalled sink parks one result in the skid register and
// freezes the chain until the sink takes a transfer.
// Reset (i_rst_n low, synchronous) clears all valid flags; payload is not reset.
module quadratic_real_roots (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qrr_in_if.sink        i_in,
    qrr_out_if.source     o_res
);

    // chain advance: every chain stage moves unless the skid register is holding a result
    logic w_en;

    // ---- front: input register, products, discriminant ----
    logic                               r_f1_v;
    logic signed [qrr_pkg::COEF_W-1:0]  r_f1_a, r_f1_b, r_f1_c;

    logic                                 r_f2_v;
    logic signed [qrr_pkg::COEF_W-1:0]    r_f2_a, r_f2_b;
    logic signed [2*qrr_pkg::COEF_W-1:0]  r_f2_p, r_f2_q;

    logic signed [qrr_pkg::DS_W-1:0]   w_d;
    logic [qrr_pkg::DW-1:0]            w_dmag;
    logic [1:0]                        w_cnt;
    qrr_pkg::t_sq                      w_sq0;

    always_comb begin
        w_d = qrr_pkg::DS_W'(r_f2_p) - (qrr_pkg::DS_W'(r_f2_q) <<< 2);
        if (r_f2_a == '0 || w_d[qrr_pkg::DS_W-1]) begin
            w_cnt = qrr_pkg::CNT_NONE;
        end else if (w_d == '0) begin
            w_cnt = qrr_pkg::CNT_ONE;
        end else begin
            w_cnt = qrr_pkg::CNT_TWO;
        end
        // no-root cases run a zero radicand; the result is zeroed at the end
        w_dmag     = (w_cnt == qrr_pkg::CNT_NONE) ? '0 : w_d[qrr_pkg::DW-1:0];
        w_sq0.rad  = {{(qrr_pkg::RAD_W-qrr_pkg::DW){1'b0}}, w_dmag} << (2*qrr_pkg::FRAC_BITS);
        w_sq0.rem  = '0;
        w_sq0.root = '0;
        w_sq0.side.a   = r_f2_a;
        w_sq0.side.b   = r_f2_b;
        w_sq0.side.cnt = w_cnt;
    end

    logic          r_f3_v;
    qrr_pkg::t_sq  r_f3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_in.valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_a <= i_in.coef_a;
            r_f1_b <= i_in.coef_b;
            r_f1_c <= i_in.coef_c;
            r_f2_a <= r_f1_a;
            r_f2_b <= r_f1_b;
            r_f2_p <= r_f1_b * r_f1_b;
            r_f2_q <= r_f1_a * r_f1_c;
            r_f3_d <= w_sq0;
        end
    end

    // ---- square root: one cell per root bit ----
    logic          w_sq_v [0:qrr_pkg::SQ_W];
    qrr_pkg::t_sq  w_sq_d [0:qrr_pkg::SQ_W];

    assign w_sq_v[0] = r_f3_v;
    assign w_sq_d[0] = r_f3_d;

    for (genvar g = 0; g < qrr_pkg::SQ_W; g++) begin : g_sq
        qrr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (w_sq_v[g]),
            .i_d     (w_sq_d[g]),
            .o_v     (w_sq_v[g+1]),
            .o_d     (w_sq_d[g+1])
        );
    end

    // ---- numerators -b*2^F +/- S, split into magnitude and quotient sign ----
    qrr_pkg::t_sq                     w_sq_end;
    logic signed [qrr_pkg::NS_W-1:0]  w_base, w_np, w_nm, w_s;
    logic [qrr_pkg::COEF_W-1:0]       w_abs_a;
    qrr_pkg::t_dv                     w_dv0;

    always_comb begin
        w_sq_end = w_sq_d[qrr_pkg::SQ_W];
        w_base = -($signed({{(qrr_pkg::NS_W-qrr_pkg::COEF_W){w_sq_end.side.b[qrr_pkg::COEF_W-1]}},
                            w_sq_end.side.b}) <<< qrr_pkg::FRAC_BITS);
        w_s    = $signed({{(qrr_pkg::NS_W-qrr_pkg::SQ_W){1'b0}}, w_sq_end.root});
        w_np   = w_base + w_s;
        w_nm   = w_base - w_s;
        w_abs_a = w_sq_end.side.a[qrr_pkg::COEF_W-1] ? qrr_pkg::COEF_W'(-w_sq_end.side.a)
                                                     : w_sq_end.side.a;
        w_dv0.nm_p  = w_np[qrr_pkg::NS_W-1] ? qrr_pkg::NM_W'(-w_np) : w_np[qrr_pkg::NM_W-1:0];
        w_dv0.nm_m  = w_nm[qrr_pkg::NS_W-1] ? qrr_pkg::NM_W'(-w_nm) : w_nm[qrr_pkg::NM_W-1:0];
        w_dv0.rm_p  = '0;
        w_dv0.rm_m  = '0;
        w_dv0.neg_p = w_np[qrr_pkg::NS_W-1] ^ w_sq_end.side.a[qrr_pkg::COEF_W-1];
        w_dv0.neg_m = w_nm[qrr_pkg::NS_W-1] ^ w_sq_end.side.a[qrr_pkg::COEF_W-1];
        w_dv0.den   = {w_abs_a, 1'b0};
        w_dv0.cnt   = w_sq_end.side.cnt;
    end

    logic          r_pr_v;
    qrr_pkg::t_dv  r_pr_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else if (w_en) begin
            r_pr_v <= w_sq_v[qrr_pkg::SQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr_d <= w_dv0;
        end
    end

    // ---- division by |2a|: one cell per quotient bit, both roots side by side ----
    logic          w_dv_v [0:qrr_pkg::NM_W];
    qrr_pkg::t_dv  w_dv_d [0:qrr_pkg::NM_W];

    assign w_dv_v[0] = r_pr_v;
    assign w_dv_d[0] = r_pr_d;

    for (genvar g = 0; g < qrr_pkg::NM_W; g++) begin : g_dv
        qrr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (w_dv_v[g]),
            .i_d     (w_dv_d[g]),
            .o_v     (w_dv_v[g+1]),
            .o_d     (w_dv_d[g+1])
        );
    end

    // ---- sign restore (truncation toward zero), zero the no-root case ----
    qrr_pkg::t_dv                        w_dv_end;
    logic signed [qrr_pkg::ROOT_W-1:0]   w_qp, w_qm;
    qrr_pkg::t_res                       w_res;

    always_comb begin
        w_dv_end = w_dv_d[qrr_pkg::NM_W];
        w_qp = $signed({{(qrr_pkg::ROOT_W-qrr_pkg::NM_W){1'b0}}, w_dv_end.nm_p});
        w_qm = $signed({{(qrr_pkg::ROOT_W-qrr_pkg::NM_W){1'b0}}, w_dv_end.nm_m});
        w_res.cnt = w_dv_end.cnt;
        if (w_dv_end.cnt == qrr_pkg::CNT_NONE) begin
            w_res.rp = '0;
            w_res.rm = '0;
        end else begin
            w_res.rp = w_dv_end.neg_p ? -w_qp : w_qp;
            w_res.rm = w_dv_end.neg_m ? -w_qm : w_qm;
        end
    end

    logic           r_fin_v;
    qrr_pkg::t_res  r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= w_dv_v[qrr_pkg::NM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= w_res;
        end
    end

    // ---- output register with skid ----
    logic           r_out_v, r_skid_v;
    qrr_pkg::t_res  r_out, r_skid;
    logic           w_take;

    assign w_en   = !r_skid_v;
    assign w_take = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_res.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_fin_v) begin
            if (w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_res.ready) begin
                r_out <= r_skid;
            end
        end else if (r_fin_v) begin
            if (w_take) begin
                r_out <= r_fin;
            end else begin
                r_skid <= r_fin;
            end
        end
    end

    assign i_in.ready       = w_en;
    assign o_res.valid      = r_out_v;
    assign o_res.root_count = r_out.cnt;
    assign o_res.root_plus  = r_out.rp;
    assign o_res.root_minus = r_out.rm;

endmodule

>>> tb/sv/quadratic_real_roots_tb.sv
`timescale 1ns / 1ps

module quadratic_real_roots_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic signed [qrr_pkg::COEF_W-1:0] a;
        logic signed [qrr_pkg::COEF_W-1:0] b;
        logic signed [qrr_pkg::COEF_W-1:0] c;
    } t_coefs;

    logic i_clk;
    logic i_rst_n;

    qrr_in_if  coef_ch ();
    qrr_out_if root_ch ();

    quadratic_real_roots u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (coef_ch.sink),
        .o_res   (root_ch.source)
    );

    t_coefs          pending_coefs[$];
    qrr_pkg::t_res   expected_roots[$];
    int     error_count;
    int     idle_cycles;
    int     cycle_count;
    bit     stimulus_done;
    bit     calm_stretch;   // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Digit-by-digit floor square root of a radicand up to 128 bits.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] rad);
        logic [63:0]  r;
        logic [129:0] rem;
        logic [129:0] trial;
        r   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | rad[2*i +: 2];
            trial = ({66'd0, r} << 2) | 130'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                r   = (r << 1) | 64'd1;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic logic signed [qrr_pkg::ROOT_W-1:0] clamp_root(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (qrr_pkg::ROOT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[qrr_pkg::ROOT_W-1:0];
    endfunction

    // Fixed-point real roots of a*x^2 + b*x + c.
    function automatic qrr_pkg::t_res solve_roots(input t_coefs k);
        qrr_pkg::t_res r;
        longint        a, b, c, disc, base, den, s;
        logic [127:0]  rad;
        a = k.a;
        b = k.b;
        c = k.c;
        r = '{cnt: qrr_pkg::CNT_NONE, rp: '0, rm: '0};
        if (a == 0) return r;
        disc = b * b - 4 * a * c;     // fits easily in 64 bits at 16-bit coefficients
        if (disc < 0) return r;
        rad  = 128'(disc) << (2 * qrr_pkg::FRAC_BITS);
        s    = longint'(floor_sqrt(rad));
        base = -b * (longint'(1) <<< qrr_pkg::FRAC_BITS);
        den  = 2 * a;
        r.cnt = (disc == 0) ? qrr_pkg::CNT_ONE : qrr_pkg::CNT_TWO;
        r.rp  = clamp_root((base + s) / den);   // SV division truncates toward zero
        r.rm  = clamp_root((base - s) / den);
        return r;
    endfunction

    function automatic logic signed [qrr_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3, 4:    return qrr_pkg::COEF_W'($urandom_range(0, 14) - 7);
            default: return qrr_pkg::COEF_W'($urandom());
        endcase
    endfunction

    task automatic queue_coefs(input int a, input int b, input int c);
        t_coefs k;
        k.a = qrr_pkg::COEF_W'(a);
        k.b = qrr_pkg::COEF_W'(b);
        k.c = qrr_pkg::COEF_W'(c);
        pending_coefs.push_back(k);
    endtask

    // Directed part, then random sets. Roughly half of the random sets are built
    // from chosen roots r1, r2 (a*(x-r1)(x-r2)) so real and double roots are common.
    initial begin
        int a, r1, r2;
        stimulus_done = 1'b0;
        queue_coefs(0, 5, 7);                   // zero leading coefficient
        queue_coefs(0, 0, 0);
        queue_coefs(1, 0, 1);                   // negative discriminant
        queue_coefs(1, -2, 1);                  // double root
        queue_coefs(-3, 12, -12);               // double root, negative a
        queue_coefs(1, -3, 2);                  // two roots
        queue_coefs(2, 3, -5);
        queue_coefs(1, 0, -2);                  // irrational roots
        queue_coefs(-1, 1, 1);
        queue_coefs(32767, 32767, 32767);
        queue_coefs(-32768, -32768, -32768);
        queue_coefs(-32768, 32767, 32767);      // large discriminant
        queue_coefs(32767, -32768, -32768);
        queue_coefs(1, -32768, 0);              // large root
        queue_coefs(-1, -32768, 0);
        queue_coefs(1, 32767, -32768);
        queue_coefs(-32768, 0, 0);
        queue_coefs(32767, 0, -32768);
        queue_coefs(1, -32768, -32768);
        queue_coefs(3, 7, 0);                   // zero constant term
        queue_coefs(-2, 0, 5);
        queue_coefs(16'hffff, 16'h5555, 16'haaaa);
        for (int i = 0; i < 1200; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                a  = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
                r1 = $urandom_range(0, 40) - 20;
                r2 = ($urandom_range(0, 3) == 0) ? r1 : $urandom_range(0, 40) - 20;
                queue_coefs(a, -a * (r1 + r2), a * r1 * r2);
            end else begin
                queue_coefs(rand_coef(), rand_coef(), rand_coef());
            end
        end
        stimulus_done = 1'b1;
    end

    // Reset once, then let the driver and monitor run.
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // A stretch without idling on either side after reset; otherwise random idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count  <= 0;
            calm_stretch <= 1'b0;
        end else begin
            cycle_count  <= cycle_count + 1;
            calm_stretch <= (cycle_count >= 300) && (cycle_count < 600);
        end
    end

    // Driver: hold the item until its transfer, then present the next or idle.
    always @(posedge i_clk) begin
        t_coefs k;
        if (!i_rst_n) begin
            coef_ch.valid  <= 1'b0;
            coef_ch.coef_a <= '0;
            coef_ch.coef_b <= '0;
            coef_ch.coef_c <= '0;
        end else if (!coef_ch.valid || coef_ch.ready) begin
            if (coef_ch.valid) begin
                expected_roots.push_back(solve_roots({coef_ch.coef_a, coef_ch.coef_b,
                                                      coef_ch.coef_c}));
            end
            if (pending_coefs.size() > 0 &&
                (calm_stretch || $urandom_range(0, 99) >= 11)) begin
                k = pending_coefs.pop_front();
                coef_ch.valid  <= 1'b1;
                coef_ch.coef_a <= k.a;
                coef_ch.coef_b <= k.b;
                coef_ch.coef_c <= k.c;
            end else begin
                coef_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        qrr_pkg::t_res exp_r;
        if (!i_rst_n) begin
            root_ch.ready <= 1'b0;
            error_count   = 0;
        end else begin
            if (root_ch.valid && root_ch.ready) begin
                if (expected_roots.size() == 0) begin
                    $error("root result with nothing expected");
                    error_count++;
                end else begin
                    exp_r = expected_roots.pop_front();
                    if (root_ch.root_count !== exp_r.cnt) begin
                        $error("root_count expected %0d actual %0d",
                               exp_r.cnt, root_ch.root_count);
                        error_count++;
                    end
                    if (root_ch.root_plus !== exp_r.rp) begin
                        $error("root_plus expected %0d actual %0d",
                               exp_r.rp, root_ch.root_plus);
                        error_count++;
                    end
                    if (root_ch.root_minus !== exp_r.rm) begin
                        $error("root_minus expected %0d actual %0d",
                               exp_r.rm, root_ch.root_minus);
                        error_count++;
                    end
                end
            end
            root_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= 11);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (coef_ch.valid && coef_ch.ready) ||
            (root_ch.valid && root_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run: all sent, all results back, then a drain window for extras.
    initial begin
        bit timed_out;
        timed_out = 1'b0;
        @(posedge i_rst_n);
        while (!timed_out && !(stimulus_done && pending_coefs.size() == 0 &&
               !coef_ch.valid && expected_roots.size() == 0)) begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        if (timed_out || error_count != 0 || expected_roots.size() != 0) begin
            $display("quadratic_real_roots test failed");
        end else begin
            $display("quadratic_real_roots test passed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/qrr_pkg.sv
sv/qrr_if.sv
sv/qrr_sqrt_cell.sv
sv/qrr_div_cell.sv
sv/quadratic_real_roots.sv
tb/sv/quadratic_real_roots_tb.sv
